// ----- design/dwspi_pkg.sv -----
// ----------------------------------------------------------------------------
// dwspi_pkg: shared types and constants of the dual wheel speed PI loop
// Register codes, configuration and item structs, sequencer steps and the
// fixed constants of the turn-term divider.
// ----------------------------------------------------------------------------
`default_nettype none

package dwspi_pkg;

    localparam int FRACTION_BITS_DEF = 12;

    // input queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 64;

    // shared multiplier
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 29;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [16:0] ALPHA_MAX = 17'd65536;

    // round(v / 1000) = floor((v + 500) / 1000); bias by 34000 * 1000 to keep
    // the dividend positive, then multiply by ceil(2^37 / 1000)
    localparam logic [MUL_A_W-1:0] TURN_OFFSET      = 33'd34000500;
    localparam logic signed [17:0] TURN_BIAS_Q      = 18'sd34000;
    localparam logic [MUL_B_W-1:0] TURN_RECIP       = 29'd137438954;
    localparam int                 TURN_RECIP_SHIFT = 37;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SPEED_SCALE    = 3'd0,
        REG_FILTER_ALPHA   = 3'd1,
        REG_HALF_SPACING   = 3'd2,
        REG_PROP_GAIN      = 3'd3,
        REG_INTEG_GAIN     = 3'd4,
        REG_ERROR_DEADBAND = 3'd5,
        REG_DRIVE_LIMIT    = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic [15:0] speed_scale;
        logic [16:0] filter_alpha;
        logic [9:0]  half_wheel_spacing;
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [11:0] error_deadband;
        logic [14:0] drive_limit;
    } t_cfg;

    // classified item: right count already negated, turn sign already set
    typedef struct packed {
        logic signed [11:0] count_left;
        logic signed [12:0] count_right_neg;
        logic signed [14:0] forward_speed;
        logic signed [16:0] turn_rate_dir;
        logic               stopped;
    } t_item;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RAW_L,
        ST_RAW_R,
        ST_FILT_L,
        ST_FILT_R,
        ST_TURN_MUL,
        ST_SPEED_L,
        ST_DIV_MUL,
        ST_DIV_WAIT,
        ST_TURN,
        ST_ERR,
        ST_PROP_L,
        ST_INTEG_L,
        ST_PROP_R,
        ST_INTEG_R,
        ST_SUM_R,
        ST_FIN_R,
        ST_OUT
    } t_step;

endpackage

`default_nettype wire

// ----- design/dual_wheel_speed_pi_loop.sv -----
// An item passes through the input queue, sixteen schedule steps on the shared
// multiplier and one output step. The back end takes a new item only once the
// last is done, as set by the schedule of the single shared 33x29 multiplier;
// the queue and output register absorb stalls on either side.
// Reset (synchronous, active low) clears filters, accumulators, last errors,
// the queue and the output valid, and loads the register defaults.
// ----------------------------------------------------------------------------
// dual_wheel_speed_pi_loop: differential drive speed loop
// Scales and smooths both wheel speeds, forms wheel targets from forward
// speed and turn rate, and runs two incremental PI loops to give the drives.
// ----------------------------------------------------------------------------
`default_nettype none

module dual_wheel_speed_pi_loop
    import dwspi_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // count_left[11:0], count_right[23:12], forward_speed[38:24],
    // turn_rate[54:39], zero fill[55]
    input  wire logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    // stopped
    input  wire logic                  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // drive_left[15:0], drive_right[31:16], speed_left[47:32],
    // speed_right[63:48]
    output logic [M_TDATA_W-1:0]       o_m_axis_tdata,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  w_cfg;
    logic  w_q_valid;
    logic  w_q_ready;
    t_item w_q_item;

    dwspi_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    dwspi_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_data    (i_s_axis_tdata),
        .i_user    (i_s_axis_tuser),
        .o_q_valid (w_q_valid),
        .i_q_ready (w_q_ready),
        .o_q_item  (w_q_item)
    );

    dwspi_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (w_cfg),
        .i_q_valid (w_q_valid),
        .o_q_ready (w_q_ready),
        .i_q_item  (w_q_item),
        .o_m_valid (o_m_axis_tvalid),
        .i_m_ready (i_m_axis_tready),
        .o_m_data  (o_m_axis_tdata)
    );

    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg.filter_alpha <= ALPHA_MAX)
        else $error("filter alpha above one");

    a_drive_symmetric: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[15:0] != 16'h8000 &&
                             o_m_axis_tdata[31:16] != 16'h8000))
        else $error("drive outside symmetric range");

    a_one_item_in_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_valid && w_q_ready) |=> !w_q_ready)
        else $error("back end took a second item while busy");

endmodule

`default_nettype wire

// ----- design/dwspi_regs.sv -----
// ----------------------------------------------------------------------------
// dwspi_regs: configuration registers
// Takes register writes by index and presents the settings as one struct.
// ----------------------------------------------------------------------------
`default_nettype none

module dwspi_regs
    import dwspi_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SPEED_SCALE:    n_cfg.speed_scale = i_cfg_data[15:0];
                REG_FILTER_ALPHA: begin
                    // saturate alpha at one
                    n_cfg.filter_alpha = (i_cfg_data > ALPHA_MAX) ? ALPHA_MAX : i_cfg_data;
                end
                REG_HALF_SPACING:   n_cfg.half_wheel_spacing = i_cfg_data[9:0];
                REG_PROP_GAIN:      n_cfg.prop_gain = i_cfg_data[15:0];
                REG_INTEG_GAIN:     n_cfg.integ_gain = i_cfg_data[15:0];
                REG_ERROR_DEADBAND: n_cfg.error_deadband = i_cfg_data[11:0];
                REG_DRIVE_LIMIT:    n_cfg.drive_limit = i_cfg_data[14:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.speed_scale        <= 16'd1678;
            r_cfg.filter_alpha       <= 17'd32768;
            r_cfg.half_wheel_spacing <= 10'd80;
            r_cfg.prop_gain          <= 16'd400;
            r_cfg.integ_gain         <= 16'd300;
            r_cfg.error_deadband     <= 12'd0;
            r_cfg.drive_limit        <= 15'd8000;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

// ----- design/dwspi_front.sv -----
// ----------------------------------------------------------------------------
// dwspi_front: input side
// Accepts items, negates the right count, sets the turn sign for reverse
// travel and holds the result in a short queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dwspi_front
    import dwspi_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    output logic                      o_ready,
    input  wire logic [S_TDATA_W-1:0] i_data,
    input  wire logic                 i_user,
    output logic                      o_q_valid,
    input  wire logic                 i_q_ready,
    output t_item                     o_q_item
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    t_item              w_item;
    logic signed [11:0] w_count_right;
    logic signed [15:0] w_turn;
    logic               w_push;
    logic               w_pop;

    always_comb begin
        w_count_right          = i_data[23:12];
        w_turn                 = i_data[54:39];
        w_item.count_left      = i_data[11:0];
        w_item.count_right_neg = -13'(w_count_right);
        w_item.forward_speed   = i_data[38:24];
        // flip the turn sense while reversing
        w_item.turn_rate_dir   = i_data[38] ? -17'(w_turn) : 17'(w_turn);
        w_item.stopped         = i_user;
    end

    assign o_ready   = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_mem[r_rd_ptr];
    assign w_push    = i_valid && o_ready;
    assign w_pop     = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= w_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/dwspi_back.sv -----
// ----------------------------------------------------------------------------
// dwspi_back: filter and PI sequencer
// Runs one item at a time through a fixed schedule on one shared registered
// multiplier: speed scaling, smoothing, turn term, then both PI loops.
// ----------------------------------------------------------------------------
`default_nettype none

module dwspi_back
    import dwspi_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire logic                 i_q_valid,
    output logic                      o_q_ready,
    input  wire t_item                i_q_item,
    output logic                      o_m_valid,
    input  wire logic                 i_m_ready,
    output logic [M_TDATA_W-1:0]      o_m_data
);

    localparam int          SHIFT      = 16 - FRACTION_BITS;
    localparam logic [32:0] SPEED_HALF = 33'((2 ** SHIFT) / 2);

    t_step                      r_state;
    t_step                      n_state;
    t_item                      r_item;
    logic signed [MUL_A_W-1:0]  r_ma;
    logic signed [MUL_B_W-1:0]  r_mb;
    logic signed [MUL_P_W-1:0]  r_prod;
    logic signed [31:0]         r_filt_l;
    logic signed [31:0]         r_filt_r;
    logic signed [15:0]         r_speed_l;
    logic signed [15:0]         r_speed_r;
    logic signed [17:0]         r_turn;
    logic signed [19:0]         r_err_l;
    logic signed [19:0]         r_err_r;
    logic signed [19:0]         r_prev_l;
    logic signed [19:0]         r_prev_r;
    logic signed [31:0]         r_acc_l;
    logic signed [31:0]         r_acc_r;
    logic signed [39:0]         r_sum;
    logic                       r_m_valid;
    logic [M_TDATA_W-1:0]       r_m_data;

    logic signed [MUL_A_W-1:0]  w_raw;
    logic signed [MUL_P_W-1:0]  w_rnd;
    logic signed [31:0]         w_filt_delta;
    logic [MUL_A_W-1:0]         w_u;
    logic [17:0]                w_quot;
    logic signed [39:0]         w_prod40;
    logic signed [39:0]         w_total;
    logic                       w_out_free;

    function automatic logic signed [15:0] f_speed(input logic signed [31:0] filt);
        logic signed [32:0] t;
        logic signed [32:0] s;
        t = 33'(filt) + $signed(SPEED_HALF);
        s = t >>> SHIFT;
        if (s > 33'sd32767) begin
            return 16'sh7fff;
        end else if (s < -33'sd32768) begin
            return 16'sh8000;
        end
        return s[15:0];
    endfunction

    function automatic logic f_in_band(input logic signed [19:0] err,
                                       input logic [11:0] band);
        logic signed [20:0] e;
        logic signed [20:0] mag;
        e   = 21'(err);
        mag = e[20] ? -e : e;
        return $unsigned(mag) < 21'(band);
    endfunction

    function automatic logic signed [31:0] f_clamp(input logic signed [39:0] a,
                                                   input logic [14:0] limit,
                                                   input logic stop);
        logic signed [39:0] lim;
        logic signed [39:0] nlim;
        lim  = $signed(40'(limit) << FRACTION_BITS);
        nlim = -lim;
        if (stop) begin
            return '0;
        end else if (a > lim) begin
            return lim[31:0];
        end else if (a < nlim) begin
            return nlim[31:0];
        end
        return a[31:0];
    endfunction

    // negated accumulator truncated toward zero to whole units
    function automatic logic [15:0] f_drive(input logic signed [31:0] acc,
                                            input logic stop);
        logic [31:0] mag;
        logic [31:0] t;
        if (stop) begin
            return '0;
        end
        if (!acc[31]) begin
            t = $unsigned(acc) >> FRACTION_BITS;
            t = -t;
        end else begin
            mag = -$unsigned(acc);
            t   = mag >> FRACTION_BITS;
        end
        return t[15:0];
    endfunction

    assign o_q_ready  = (r_state == ST_IDLE);
    assign o_m_valid  = r_m_valid;
    assign o_m_data   = r_m_data;
    assign w_out_free = !r_m_valid || i_m_ready;

    always_comb begin
        w_raw        = MUL_A_W'($signed(r_prod[27:0]));
        w_rnd        = r_prod + MUL_P_W'(32768);
        w_filt_delta = w_rnd[47:16];
        w_u          = r_prod[MUL_A_W-1:0] + TURN_OFFSET;
        w_quot       = r_prod[TURN_RECIP_SHIFT+17:TURN_RECIP_SHIFT];
        w_prod40     = r_prod[39:0];
        w_total      = r_sum + w_prod40;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:     if (i_q_valid) n_state = ST_RAW_L;
            ST_RAW_L:    n_state = ST_RAW_R;
            ST_RAW_R:    n_state = ST_FILT_L;
            ST_FILT_L:   n_state = ST_FILT_R;
            ST_FILT_R:   n_state = ST_TURN_MUL;
            ST_TURN_MUL: n_state = ST_SPEED_L;
            ST_SPEED_L:  n_state = ST_DIV_MUL;
            ST_DIV_MUL:  n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: n_state = ST_TURN;
            ST_TURN:     n_state = ST_ERR;
            ST_ERR:      n_state = ST_PROP_L;
            ST_PROP_L:   n_state = ST_INTEG_L;
            ST_INTEG_L:  n_state = ST_PROP_R;
            ST_PROP_R:   n_state = ST_INTEG_R;
            ST_INTEG_R:  n_state = ST_SUM_R;
            ST_SUM_R:    n_state = ST_FIN_R;
            ST_FIN_R:    n_state = ST_OUT;
            ST_OUT:      if (w_out_free) n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // shared multiplier: operands registered in r_ma and r_mb, product registered in r_prod
    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    r_item <= i_q_item;
                end
            end
            ST_RAW_L: begin
                r_ma <= MUL_A_W'(r_item.count_left);
                r_mb <= MUL_B_W'(i_cfg.speed_scale);
            end
            ST_RAW_R: begin
                r_ma <= MUL_A_W'(r_item.count_right_neg);
                r_mb <= MUL_B_W'(i_cfg.speed_scale);
            end
            ST_FILT_L: begin
                r_ma <= w_raw - MUL_A_W'(r_filt_l);
                r_mb <= MUL_B_W'(i_cfg.filter_alpha);
            end
            ST_FILT_R: begin
                r_ma <= w_raw - MUL_A_W'(r_filt_r);
                r_mb <= MUL_B_W'(i_cfg.filter_alpha);
            end
            ST_TURN_MUL: begin
                r_ma <= MUL_A_W'(r_item.turn_rate_dir);
                r_mb <= MUL_B_W'(i_cfg.half_wheel_spacing);
            end
            ST_DIV_MUL: begin
                r_ma <= $signed(w_u);
                r_mb <= $signed(TURN_RECIP);
            end
            ST_TURN: begin
                r_turn <= $signed(w_quot) - TURN_BIAS_Q;
            end
            ST_ERR: begin
                r_err_l <= 20'(r_item.forward_speed) - 20'(r_turn) - 20'(r_speed_l);
                r_err_r <= 20'(r_item.forward_speed) + 20'(r_turn) - 20'(r_speed_r);
            end
            ST_PROP_L: begin
                r_ma <= MUL_A_W'(r_err_l) - MUL_A_W'(r_prev_l);
                r_mb <= MUL_B_W'(i_cfg.prop_gain);
            end
            ST_INTEG_L: begin
                r_ma <= MUL_A_W'(r_err_l);
                r_mb <= MUL_B_W'(i_cfg.integ_gain);
            end
            ST_PROP_R: begin
                r_sum <= 40'(r_acc_l) + w_prod40;
                r_ma  <= MUL_A_W'(r_err_r) - MUL_A_W'(r_prev_r);
                r_mb  <= MUL_B_W'(i_cfg.prop_gain);
            end
            ST_INTEG_R: begin
                r_ma <= MUL_A_W'(r_err_r);
                r_mb <= MUL_B_W'(i_cfg.integ_gain);
            end
            ST_SUM_R: begin
                r_sum <= 40'(r_acc_r) + w_prod40;
            end
            ST_OUT: begin
                if (w_out_free) begin
                    r_m_data <= {r_speed_r, r_speed_l,
                                 f_drive(r_acc_r, r_item.stopped),
                                 f_drive(r_acc_l, r_item.stopped)};
                end
            end
            default: begin
            end
        endcase
    end

    // loop state: filters, accumulators, last errors, and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt_l  <= '0;
            r_filt_r  <= '0;
            r_acc_l   <= '0;
            r_acc_r   <= '0;
            r_prev_l  <= '0;
            r_prev_r  <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (r_m_valid && i_m_ready) begin
                r_m_valid <= 1'b0;
            end
            unique case (r_state)
                ST_TURN_MUL: r_filt_l <= r_filt_l + w_filt_delta;
                ST_SPEED_L:  r_filt_r <= r_filt_r + w_filt_delta;
                ST_INTEG_R: begin
                    // inside the deadband: track the error, hold the drive
                    if (!f_in_band(r_err_l, i_cfg.error_deadband)) begin
                        r_acc_l <= f_clamp(w_total, i_cfg.drive_limit, r_item.stopped);
                    end
                    r_prev_l <= r_err_l;
                end
                ST_FIN_R: begin
                    if (!f_in_band(r_err_r, i_cfg.error_deadband)) begin
                        r_acc_r <= f_clamp(w_total, i_cfg.drive_limit, r_item.stopped);
                    end
                    r_prev_r <= r_err_r;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_SPEED_L: r_speed_l <= f_speed(r_filt_l);
            ST_DIV_MUL: r_speed_r <= f_speed(r_filt_r);
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire
